>>> src/assert_macros.svh
// Assertion macros used by the datapath of the stack machine step block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define FSSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that a condition is followed in the next cycle by another
`define FSSM_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);

`endif

>>> src/fssm_pkg.sv
// Package of the stack machine step block: sizes, character codes, word types.
// Depends on nothing; imported by every module of the block but fssm_ram.
package fssm_pkg;

  localparam int GRID_COLUMNS = 80;
  localparam int GRID_ROWS    = 25;
  localparam int STACK_DEPTH  = 1024;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int WORD_W     = 64;
  localparam int GRID_CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int GRID_AW    = $clog2(GRID_CELLS);
  localparam int STACK_AW   = $clog2(STACK_DEPTH);
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W     = $clog2(WORD_W);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_CARET      = 8'h5E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKTICK   = 8'h60;
  localparam logic [7:0] CH_LOWER_G    = 8'h67;
  localparam logic [7:0] CH_LOWER_P    = 8'h70;
  localparam logic [7:0] CH_LOWER_V    = 8'h76;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_TILDE      = 8'h7E;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DIV  = 2'd1,
    FAULT_OVF  = 2'd2,
    FAULT_GRID = 2'd3
  } fault_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_OPLATCH,
    ST_POP,
    ST_POPWT,
    ST_OPER,
    ST_MDWAIT,
    ST_GWAIT,
    ST_PUSH,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                     command;
    logic [COL_W-1:0]         load_column;
    logic [ROW_W-1:0]         load_row;
    logic [7:0]               load_char;
    logic signed [WORD_W-1:0] user_number;
    logic [7:0]               user_char;
    logic [1:0]               random_pick;
  } in_word_t;

  typedef struct packed {
    logic                     out_valid;
    logic                     out_kind;
    logic signed [WORD_W-1:0] out_value;
    logic                     halted;
    logic [1:0]               fault;
    logic [COL_W-1:0]         pc_column;
    logic [ROW_W-1:0]         pc_row;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic fetch;
    logic oplatch;
    logic pop_issue;
    logic pop_zero;
    logic pop_capture;
    logic oper;
    logic md_capture;
    logic g_capture;
    logic push;
    logic done;
    logic clear_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic stopped;
    logic pops_left;
    logic cnt_zero;
    logic need_md;
    logic need_gread;
    logic push_left;
    logic md_done;
    logic clr_last;
  } dp_status_t;

endpackage

>>> src/fssm_ram.sv
// Generic simple dual-port RAM with registered read.
// Depends on nothing; holds the program grid and the value stack.
module fssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fssm_md.sv
// Iterative 64-bit multiplier and signed divider, one bit per cycle.
// Depends on fssm_pkg.
module fssm_md
  import fssm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mul_i,
  input  logic              rem_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic              done_o,
  output logic [WORD_W-1:0] res_o
);

  logic              run_q, fix_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [WORD_W-1:0] acc_q, quo_q, dvs_q, res_q;
  logic              mul_q, rem_q, negq_q, negr_q;
  logic [WORD_W-1:0] shl;
  logic              ge;

  assign shl = {acc_q[WORD_W-2:0], quo_q[WORD_W-1]};
  assign ge  = (shl >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(WORD_W - 1)) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      mul_q  <= mul_i;
      rem_q  <= rem_i;
      negq_q <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      negr_q <= b_i[WORD_W-1];
      if (mul_i) begin
        quo_q <= a_i;
        dvs_q <= b_i;
      end else begin
        quo_q <= b_i[WORD_W-1] ? (WORD_W'(0) - b_i) : b_i;
        dvs_q <= a_i[WORD_W-1] ? (WORD_W'(0) - a_i) : a_i;
      end
    end else if (run_q) begin
      if (mul_q) begin
        if (quo_q[0]) begin
          acc_q <= acc_q + dvs_q;
        end
        quo_q <= {1'b0, quo_q[WORD_W-1:1]};
        dvs_q <= {dvs_q[WORD_W-2:0], 1'b0};
      end else begin
        acc_q <= ge ? (shl - dvs_q) : shl;
        quo_q <= {quo_q[WORD_W-2:0], ge};
      end
    end
    if (fix_q) begin
      if (mul_q) begin
        res_q <= acc_q;
      end else if (rem_q) begin
        res_q <= negr_q ? (WORD_W'(0) - acc_q) : acc_q;
      end else begin
        res_q <= negq_q ? (WORD_W'(0) - quo_q) : quo_q;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/fssm_ctrl.sv
// Controller state machine that sequences the grid clear, load, fetch, pop, execute and push.
// Depends on fssm_pkg; drives the datapath through ctrl_cmd_t.
module fssm_ctrl
  import fssm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:    if (start_i) state_d = ST_FETCH;
      ST_FETCH: begin
        if (status_i.is_load) state_d = ST_LOAD;
        else if (status_i.stopped) state_d = ST_DONE;
        else state_d = ST_OPLATCH;
      end
      ST_LOAD:    state_d = ST_DONE;
      ST_OPLATCH: state_d = ST_POP;
      ST_POP: begin
        if (!status_i.pops_left) state_d = ST_OPER;
        else if (!status_i.cnt_zero) state_d = ST_POPWT;
      end
      ST_POPWT:   state_d = ST_POP;
      ST_OPER: begin
        if (status_i.need_md) state_d = ST_MDWAIT;
        else if (status_i.need_gread) state_d = ST_GWAIT;
        else state_d = ST_PUSH;
      end
      ST_MDWAIT:  if (status_i.md_done) state_d = ST_PUSH;
      ST_GWAIT:   state_d = ST_PUSH;
      ST_PUSH:    if (!status_i.push_left) state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:   cmd_o.clear_write = 1'b1;
      ST_IDLE:    cmd_o.capture = start_i;
      ST_FETCH:   cmd_o.fetch = 1'b1;
      ST_LOAD:    cmd_o.load = 1'b1;
      ST_OPLATCH: cmd_o.oplatch = 1'b1;
      ST_POP: begin
        cmd_o.pop_zero  = status_i.pops_left & status_i.cnt_zero;
        cmd_o.pop_issue = status_i.pops_left & ~status_i.cnt_zero;
      end
      ST_POPWT:   cmd_o.pop_capture = 1'b1;
      ST_OPER:    cmd_o.oper = 1'b1;
      ST_MDWAIT:  cmd_o.md_capture = status_i.md_done;
      ST_GWAIT:   cmd_o.g_capture = 1'b1;
      ST_PUSH:    cmd_o.push = status_i.push_left;
      ST_DONE:    cmd_o.done = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> src/fssm_dp.sv
// Datapath: program grid, value stack, program counter and operation logic.
// Depends on fssm_pkg, fssm_ram, fssm_md and assert_macros.svh.
`include "assert_macros.svh"
module fssm_dp
  import fssm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  in_word_t   word_i,
  output dp_status_t status_o,
  output logic       done_o,
  output out_word_t  result_o
);

  function automatic logic [GRID_AW-1:0] cell_addr(logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row);
    return GRID_AW'(int'(row) * GRID_COLUMNS + int'(col));
  endfunction

  function automatic logic [WORD_W-1:0] sext8(logic [7:0] b);
    return {{(WORD_W-8){b[7]}}, b};
  endfunction

  function automatic logic [1:0] pop_need(logic [7:0] op, logic quote);
    logic [1:0] n;
    n = 2'd0;
    if (!quote) begin
      case (op)
        CH_DOLLAR, CH_DOT, CH_COMMA, CH_UNDERSCORE, CH_BAR, CH_COLON, CH_BANG:
          n = 2'd1;
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_BACKSLASH,
        CH_LOWER_G, CH_BACKTICK:
          n = 2'd2;
        CH_LOWER_P:
          n = 2'd3;
        default:
          n = 2'd0;
      endcase
    end
    return n;
  endfunction

  function automatic logic [COL_W+ROW_W-1:0] next_pc(logic [COL_W-1:0] col,
                                                     logic [ROW_W-1:0] row,
                                                     heading_e h);
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    c = col;
    r = row;
    case (h)
      HEAD_UP:    r = (row == '0) ? ROW_W'(GRID_ROWS - 1) : row - ROW_W'(1);
      HEAD_RIGHT: c = (int'(col) + 1 >= GRID_COLUMNS) ? '0 : col + COL_W'(1);
      HEAD_DOWN:  r = (int'(row) + 1 >= GRID_ROWS) ? '0 : row + ROW_W'(1);
      default:    c = (col == '0) ? COL_W'(GRID_COLUMNS - 1) : col - COL_W'(1);
    endcase
    return {c, r};
  endfunction

  in_word_t          in_q;
  logic [7:0]        op_q;
  logic [WORD_W-1:0] opa_q, opb_q, opc_q, oval_q;
  logic [WORD_W-1:0] pv_q [2];
  logic [COL_W-1:0]  pc_col_q;
  logic [ROW_W-1:0]  pc_row_q;
  heading_e          head_q;
  logic              quote_q, stop_q, move_q, ov_q, ok_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [1:0]        pidx_q, sidx_q, npush_q;
  fault_e            fault_q;
  logic [GRID_AW-1:0] clr_q;

  logic               load_on, xy_on, md_start;
  logic               g_we, g_is_put;
  logic [GRID_AW-1:0] g_waddr, g_raddr, xy_addr;
  logic [7:0]         g_wdata, g_rdata;
  logic               s_we;
  logic [WORD_W-1:0]  s_rdata, pop_val, md_res;
  logic               md_done, stack_room;
  logic [COL_W+ROW_W-1:0] pc_adv;

  assign load_on  = (int'(in_q.load_column) < GRID_COLUMNS) &&
                    (int'(in_q.load_row) < GRID_ROWS);
  assign xy_on    = (opb_q < WORD_W'(GRID_COLUMNS)) && (opa_q < WORD_W'(GRID_ROWS));
  assign xy_addr  = cell_addr(opb_q[COL_W-1:0], opa_q[ROW_W-1:0]);
  assign g_is_put = cmd_i.oper && !quote_q && (op_q == CH_LOWER_P) && xy_on;
  assign pc_adv   = next_pc(pc_col_q, pc_row_q, head_q);
  assign stack_room = (cnt_q < CNT_W'(STACK_DEPTH));

  always_comb begin
    g_we    = 1'b0;
    g_waddr = clr_q;
    g_wdata = CH_SPACE;
    if (cmd_i.clear_write) begin
      g_we = 1'b1;
    end else if (cmd_i.load) begin
      g_we    = load_on;
      g_waddr = cell_addr(in_q.load_column, in_q.load_row);
      g_wdata = in_q.load_char;
    end else if (g_is_put) begin
      g_we    = 1'b1;
      g_waddr = xy_addr;
      g_wdata = opc_q[7:0];
    end
    g_raddr = cmd_i.fetch ? cell_addr(pc_col_q, pc_row_q) : xy_addr;
  end

  fssm_ram #(.WIDTH(8), .DEPTH(GRID_CELLS)) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  assign s_we = cmd_i.push && stack_room;

  fssm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (cnt_q[STACK_AW-1:0]),
    .wdata_i (pv_q[sidx_q[0]]),
    .raddr_i (STACK_AW'(cnt_q - CNT_W'(1))),
    .rdata_o (s_rdata)
  );

  assign md_start = cmd_i.oper && status_o.need_md;

  fssm_md u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mul_i   (op_q == CH_STAR),
    .rem_i   (op_q == CH_PERCENT),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  assign pop_val = cmd_i.pop_capture ? s_rdata : '0;

  always_comb begin
    status_o            = '0;
    status_o.is_load    = (in_q.command == CMD_LOAD);
    status_o.stopped    = stop_q;
    status_o.pops_left  = (pidx_q < pop_need(op_q, quote_q));
    status_o.cnt_zero   = (cnt_q == '0);
    status_o.need_md    = !quote_q && ((op_q == CH_STAR) ||
                          (((op_q == CH_SLASH) || (op_q == CH_PERCENT)) && (opa_q != '0)));
    status_o.need_gread = !quote_q && (op_q == CH_LOWER_G) && xy_on;
    status_o.push_left  = (sidx_q < npush_q);
    status_o.md_done    = md_done;
    status_o.clr_last   = (clr_q == GRID_AW'(GRID_CELLS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_col_q <= '0;
      pc_row_q <= '0;
      head_q   <= HEAD_RIGHT;
      quote_q  <= 1'b0;
      stop_q   <= 1'b0;
      move_q   <= 1'b0;
      ov_q     <= 1'b0;
      ok_q     <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      pidx_q   <= '0;
      sidx_q   <= '0;
      npush_q  <= '0;
      fault_q  <= FAULT_NONE;
      clr_q    <= '0;
    end else begin
      done_q <= cmd_i.done;
      if (cmd_i.clear_write) begin
        clr_q <= clr_q + GRID_AW'(1);
      end
      if (cmd_i.capture) begin
        fault_q <= FAULT_NONE;
        ov_q    <= 1'b0;
        ok_q    <= 1'b0;
        move_q  <= 1'b0;
        pidx_q  <= '0;
        sidx_q  <= '0;
        npush_q <= '0;
      end
      if (cmd_i.load && !load_on) begin
        fault_q <= FAULT_GRID;
      end
      if (cmd_i.pop_issue) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.pop_zero || cmd_i.pop_capture) begin
        pidx_q <= pidx_q + 2'd1;
      end
      if (cmd_i.oper) begin
        move_q <= 1'b1;
        if (quote_q) begin
          if (op_q == CH_QUOTE) quote_q <= 1'b0;
          else npush_q <= 2'd1;
        end else begin
          case (op_q)
            CH_QUOTE:      quote_q <= 1'b1;
            CH_DOT, CH_COMMA: begin
              ov_q <= 1'b1;
              ok_q <= (op_q == CH_COMMA);
            end
            CH_PLUS, CH_MINUS, CH_STAR, CH_BANG, CH_BACKTICK, CH_AMP, CH_TILDE:
              npush_q <= 2'd1;
            CH_SLASH, CH_PERCENT: begin
              npush_q <= 2'd1;
              if (opa_q == '0) fault_q <= FAULT_DIV;
            end
            CH_GT:         head_q <= HEAD_RIGHT;
            CH_LT:         head_q <= HEAD_LEFT;
            CH_CARET:      head_q <= HEAD_UP;
            CH_LOWER_V:    head_q <= HEAD_DOWN;
            CH_UNDERSCORE: head_q <= (opa_q != '0) ? HEAD_LEFT : HEAD_RIGHT;
            CH_BAR:        head_q <= (opa_q != '0) ? HEAD_UP : HEAD_DOWN;
            CH_COLON, CH_BACKSLASH: npush_q <= 2'd2;
            CH_HASH:       {pc_col_q, pc_row_q} <= pc_adv;
            CH_LOWER_G: begin
              npush_q <= 2'd1;
              if (!xy_on) fault_q <= FAULT_GRID;
            end
            CH_LOWER_P:    if (!xy_on) fault_q <= FAULT_GRID;
            CH_AT: begin
              stop_q <= 1'b1;
              move_q <= 1'b0;
            end
            CH_QUESTION:   head_q <= heading_e'(in_q.random_pick);
            default:       if (op_q >= CH_ZERO && op_q <= CH_NINE) npush_q <= 2'd1;
          endcase
        end
      end
      if (cmd_i.push) begin
        sidx_q <= sidx_q + 2'd1;
        if (stack_room) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else if (fault_q == FAULT_NONE) begin
          fault_q <= FAULT_OVF;
        end
      end
      if (cmd_i.done && move_q) begin
        {pc_col_q, pc_row_q} <= pc_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q   <= word_i;
      oval_q <= '0;
    end
    if (cmd_i.oplatch) begin
      op_q <= g_rdata;
    end
    if (cmd_i.pop_zero || cmd_i.pop_capture) begin
      case (pidx_q)
        2'd0:    opa_q <= pop_val;
        2'd1:    opb_q <= pop_val;
        default: opc_q <= pop_val;
      endcase
    end
    if (cmd_i.oper) begin
      pv_q[0] <= '0;
      pv_q[1] <= opb_q;
      if (quote_q) begin
        pv_q[0] <= sext8(op_q);
      end else begin
        case (op_q)
          CH_DOT, CH_COMMA:       oval_q <= opa_q;
          CH_PLUS:                pv_q[0] <= opb_q + opa_q;
          CH_MINUS:               pv_q[0] <= opb_q - opa_q;
          CH_COLON: begin
            pv_q[0] <= opa_q;
            pv_q[1] <= opa_q;
          end
          CH_BACKSLASH:           pv_q[0] <= opa_q;
          CH_BANG:                pv_q[0] <= WORD_W'(opa_q == '0);
          CH_BACKTICK:            pv_q[0] <= WORD_W'($signed(opb_q) > $signed(opa_q));
          CH_AMP:                 pv_q[0] <= in_q.user_number;
          CH_TILDE:               pv_q[0] <= sext8(in_q.user_char);
          default: begin
            if (op_q >= CH_ZERO && op_q <= CH_NINE) pv_q[0] <= WORD_W'(op_q - CH_ZERO);
          end
        endcase
      end
    end
    if (cmd_i.md_capture) begin
      pv_q[0] <= md_res;
    end
    if (cmd_i.g_capture) begin
      pv_q[0] <= sext8(g_rdata);
    end
  end

  always_comb begin
    result_o           = '0;
    result_o.out_valid = ov_q;
    result_o.out_kind  = ok_q;
    result_o.out_value = ov_q ? oval_q : '0;
    result_o.halted    = stop_q;
    result_o.fault     = fault_q;
    result_o.pc_column = pc_col_q;
    result_o.pc_row    = pc_row_q;
  end

  assign done_o = done_q;

  `FSSM_ASSERT(a_cnt_bound, clk_i, rst_ni, (cnt_q <= CNT_W'(STACK_DEPTH)), "stack count beyond depth")
  `FSSM_ASSERT_NEXT(a_stop_sticky, clk_i, rst_ni, stop_q, stop_q, "halt flag cleared")
  `FSSM_ASSERT(a_pc_grid, clk_i, rst_ni, ((int'(pc_col_q) < GRID_COLUMNS) && (int'(pc_row_q) < GRID_ROWS)), "program counter off grid")

endmodule

>>> src/fungespace_stack_machine_step.sv
// Top level of the stack machine step block: controller plus datapath.
// Depends on fssm_pkg, fssm_ctrl and fssm_dp.
//
// Usage: drive word_i and raise start; the word is taken at a rising edge
// where start is high and busy is low. command 0 writes one grid cell,
// command 1 executes the cell under the program counter.
// Exactly one result word follows each input word: done_o is high for one
// cycle with result_o valid in that cycle. The receiver cannot stall; a
// result not taken in its cycle is lost. busy is low in the done_o cycle,
// so the next word may be taken at the edge that ends it.
// Sequence: a load passes FETCH, LOAD and DONE; a step while halted passes
// FETCH and DONE; any other step passes FETCH, OPLATCH, POP (plus POPWT per
// value popped from memory), OPER, then MDWAIT on the bit-serial unit for
// multiply and nonzero divide or modulo, or GWAIT for an in-grid g, then PUSH and DONE.
// One word is in flight at a time; the next is taken only once the last is done.
// Reset: asynchronous, active low. After reset the grid is swept to spaces,
// one cell a cycle, with busy high; then the block is idle.
module fungespace_stack_machine_step
  import fssm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  word_i,
  output logic      done_o,
  output out_word_t result_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fssm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fssm_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .word_i   (word_i),
    .status_o (status),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

>>> sim/fungespace_stack_machine_step_tb.sv
// Testbench of the stack machine step block: loads small programs, steps them and
// checks every result word against a predictor kept in the bench. Depends on fssm_pkg and the top level.
module fungespace_stack_machine_step_tb;
  import fssm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  word_i;
  logic      done_o;
  out_word_t result_o;

  fungespace_stack_machine_step i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .word_i(word_i), .done_o(done_o), .result_o(result_o)
  );

  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  logic [7:0]  grid_m [GRID_CELLS];
  logic [63:0] stk_m [STACK_DEPTH];
  int          depth_m;
  int          pc_col_m, pc_row_m;
  heading_e    head_m;
  bit          quoting_m, stopped_m;
  fault_e      flt_m;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        n_fail, n_items, n_steps, n_prints, n_faults;
  bit        feeding_done;

  function automatic logic [63:0] sx8(logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  function automatic void push_m(logic [63:0] v);
    if (depth_m >= STACK_DEPTH) begin
      if (flt_m == FAULT_NONE) flt_m = FAULT_OVF;
      return;
    end
    stk_m[depth_m] = v;
    depth_m++;
  endfunction

  function automatic logic [63:0] pop_m();
    if (depth_m == 0) return 64'd0;
    depth_m--;
    return stk_m[depth_m];
  endfunction

  function automatic bit in_grid(logic [63:0] x, logic [63:0] y);
    return !x[63] && !y[63] && x < GRID_COLUMNS && y < GRID_ROWS;
  endfunction

  function automatic void move_m();
    case (head_m)
      HEAD_UP:    pc_row_m = (pc_row_m == 0) ? GRID_ROWS - 1 : pc_row_m - 1;
      HEAD_RIGHT: pc_col_m = (pc_col_m + 1 >= GRID_COLUMNS) ? 0 : pc_col_m + 1;
      HEAD_DOWN:  pc_row_m = (pc_row_m + 1 >= GRID_ROWS) ? 0 : pc_row_m + 1;
      default:    pc_col_m = (pc_col_m == 0) ? GRID_COLUMNS - 1 : pc_col_m - 1;
    endcase
  endfunction

  function automatic out_word_t predict_step(in_word_t w);
    out_word_t   r;
    logic [63:0] a, b, c, ua, ub, uq, ur;
    logic [7:0]  op;
    bit          moving;
    r = '0;
    flt_m = FAULT_NONE;
    if (w.command == CMD_LOAD) begin
      if (w.load_column < GRID_COLUMNS && w.load_row < GRID_ROWS)
        grid_m[w.load_row * GRID_COLUMNS + w.load_column] = w.load_char;
      else
        flt_m = FAULT_GRID;
    end else if (!stopped_m) begin
      op = grid_m[pc_row_m * GRID_COLUMNS + pc_col_m];
      if (quoting_m) begin
        if (op == CH_QUOTE) quoting_m = 0;
        else push_m(sx8(op));
        move_m();
      end else begin
        moving = 1;
        case (op)
          CH_QUOTE:  quoting_m = 1;
          CH_DOLLAR: a = pop_m();
          CH_DOT: begin
            r.out_valid = 1; r.out_value = pop_m();
          end
          CH_COMMA: begin
            r.out_valid = 1; r.out_kind = 1; r.out_value = pop_m();
          end
          CH_PLUS: begin a = pop_m(); b = pop_m(); push_m(b + a); end
          CH_MINUS: begin a = pop_m(); b = pop_m(); push_m(b - a); end
          CH_STAR: begin a = pop_m(); b = pop_m(); push_m(b * a); end
          CH_SLASH, CH_PERCENT: begin
            a = pop_m(); b = pop_m();
            if (a == 0) begin
              flt_m = FAULT_DIV;
              push_m(64'd0);
            end else begin
              ub = b[63] ? -b : b;
              ua = a[63] ? -a : a;
              uq = ub / ua;
              ur = ub % ua;
              if (op == CH_SLASH) push_m((b[63] != a[63]) ? -uq : uq);
              else push_m(b[63] ? -ur : ur);
            end
          end
          CH_GT:         head_m = HEAD_RIGHT;
          CH_LT:         head_m = HEAD_LEFT;
          CH_CARET:      head_m = HEAD_UP;
          CH_LOWER_V:    head_m = HEAD_DOWN;
          CH_UNDERSCORE: head_m = (pop_m() != 0) ? HEAD_LEFT : HEAD_RIGHT;
          CH_BAR:        head_m = (pop_m() != 0) ? HEAD_UP : HEAD_DOWN;
          CH_COLON: begin a = pop_m(); push_m(a); push_m(a); end
          CH_BACKSLASH: begin a = pop_m(); b = pop_m(); push_m(a); push_m(b); end
          CH_HASH: move_m();
          CH_LOWER_G: begin
            a = pop_m(); b = pop_m();
            if (in_grid(b, a)) push_m(sx8(grid_m[a * GRID_COLUMNS + b]));
            else begin
              flt_m = FAULT_GRID;
              push_m(64'd0);
            end
          end
          CH_LOWER_P: begin
            a = pop_m(); b = pop_m(); c = pop_m();
            if (in_grid(b, a)) grid_m[a * GRID_COLUMNS + b] = c[7:0];
            else flt_m = FAULT_GRID;
          end
          CH_AT: begin stopped_m = 1; moving = 0; end
          CH_BANG: push_m((pop_m() == 0) ? 64'd1 : 64'd0);
          CH_BACKTICK: begin
            a = pop_m(); b = pop_m();
            push_m(((b ^ SIGN) > (a ^ SIGN)) ? 64'd1 : 64'd0);
          end
          CH_QUESTION: head_m = heading_e'(w.random_pick);
          CH_AMP:      push_m(w.user_number);
          CH_TILDE:    push_m(sx8(w.user_char));
          default:
            if (op >= CH_ZERO && op <= CH_NINE) push_m(64'(op - CH_ZERO));
        endcase
        if (moving) move_m();
      end
    end
    r.halted    = stopped_m;
    r.fault     = flt_m;
    r.pc_column = pc_col_m[COL_W-1:0];
    r.pc_row    = pc_row_m[ROW_W-1:0];
    return r;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.command     = 1'($urandom_range(0, 1));
    w.load_column = COL_W'($urandom);
    w.load_row    = ROW_W'($urandom);
    w.load_char   = 8'($urandom);
    w.user_number = {$urandom, $urandom};
    w.user_char   = 8'($urandom);
    w.random_pick = 2'($urandom);
    return w;
  endfunction

  function automatic logic [63:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return SIGN;
      2: return ~SIGN;
      3: return '1;
      4: return 64'($urandom_range(0, 30)) - 64'd5;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    logic [7:0] ops[27] = '{CH_SPACE, CH_BANG, CH_QUOTE, CH_HASH, CH_DOLLAR,
      CH_PERCENT, CH_AMP, CH_STAR, CH_PLUS, CH_COMMA, CH_MINUS, CH_DOT, CH_SLASH,
      CH_COLON, CH_LT, CH_GT, CH_QUESTION, CH_AT, CH_BACKSLASH, CH_CARET,
      CH_UNDERSCORE, CH_BACKTICK, CH_LOWER_G, CH_LOWER_P, CH_LOWER_V, CH_BAR, CH_TILDE};
    int k;
    k = $urandom_range(0, 39);
    if (k < 27) return ops[k];
    if (k < 37) return CH_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom);
  endfunction

  task automatic add_load(int col, int row, logic [7:0] ch);
    in_word_t w;
    w = rand_word();
    w.command = CMD_LOAD;
    w.load_column = COL_W'(col);
    w.load_row = ROW_W'(row);
    w.load_char = ch;
    pending_words.push_back(w);
  endtask

  task automatic add_step(logic [63:0] num, logic [7:0] uc, logic [1:0] pick);
    in_word_t w;
    w = rand_word();
    w.command = CMD_STEP;
    w.user_number = num;
    w.user_char = uc;
    w.random_pick = pick;
    pending_words.push_back(w);
  endtask

  // directed: a program in row 0 that touches the arithmetic corners
  task automatic fill_directed();
    string prog;
    prog = "&&/&&%0&&%\"A\"..,9!!,01g.12-0g,77p:\\`._|";
    foreach (prog[i]) add_load(i, 0, prog[i]);
    add_load(127, 0, CH_AT);
    add_load(0, 31, CH_AT);
    add_step(SIGN, 8'h00, 2'd0);
    add_step('1, 8'hFF, 2'd0);
    add_step(SIGN, 8'h80, 2'd1);
    add_step('1, 8'h7F, 2'd2);
    add_step(64'd0, 8'h00, 2'd3);
  endtask

  task automatic fill_random();
    int n, len, c0, r0;
    while (n < 1000) begin
      // short random program mostly in one row, then a run of steps
      r0 = $urandom_range(0, GRID_ROWS - 1);
      c0 = $urandom_range(0, GRID_COLUMNS - 1);
      len = $urandom_range(3, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 30) == 0)
          add_load($urandom_range(GRID_COLUMNS, 127), $urandom, 8'($urandom));
        else
          add_load((c0 + i) % GRID_COLUMNS, $urandom_range(0, 3) == 0 ?
                   $urandom_range(0, GRID_ROWS - 1) : r0, rand_op());
      end
      n += len;
      len = $urandom_range(10, 60);
      for (int i = 0; i < len; i++) add_step(rand_num(), 8'($urandom), 2'($urandom));
      n += len;
    end
  endtask

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
  end

  initial begin
    foreach (grid_m[i]) grid_m[i] = CH_SPACE;
    depth_m = 0; pc_col_m = 0; pc_row_m = 0; head_m = HEAD_RIGHT;
    quoting_m = 0; stopped_m = 0;
    fill_directed();
    fill_random();
    feeding_done = 1;
  end

  // driver: hold a word until taken, then wait a random gap
  int gap;
  initial begin
    start = 0;
    word_i = '0;
  end
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(predict_step(word_i));
        n_items++;
        if (word_i.command == CMD_STEP) n_steps++;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap == 0 && pending_words.size() > 0) begin
          word_i <= pending_words.pop_front();
        end else begin
          start <= 0;
        end
      end else if (!start) begin
        if (gap > 0) gap--;
        else if (pending_words.size() > 0) begin
          word_i <= pending_words.pop_front();
          start <= 1;
        end
      end
    end
  end

  out_word_t want;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        if (want.out_valid) n_prints++;
        if (want.fault != FAULT_NONE) n_faults++;
        if (result_o.out_valid !== want.out_valid) begin
          $error("out_valid exp %0d got %0d", want.out_valid, result_o.out_valid); n_fail++;
        end
        if (result_o.out_kind !== want.out_kind) begin
          $error("out_kind exp %0d got %0d", want.out_kind, result_o.out_kind); n_fail++;
        end
        if (result_o.out_value !== want.out_value) begin
          $error("out_value exp %0d got %0d", want.out_value, result_o.out_value); n_fail++;
        end
        if (result_o.halted !== want.halted) begin
          $error("halted exp %0d got %0d", want.halted, result_o.halted); n_fail++;
        end
        if (result_o.fault !== want.fault) begin
          $error("fault exp %0d got %0d", want.fault, result_o.fault); n_fail++;
        end
        if (result_o.pc_column !== want.pc_column) begin
          $error("pc_column exp %0d got %0d", want.pc_column, result_o.pc_column); n_fail++;
        end
        if (result_o.pc_row !== want.pc_row) begin
          $error("pc_row exp %0d got %0d", want.pc_row, result_o.pc_row); n_fail++;
        end
      end
    end
  end

  initial begin
    wait (rst_ni && feeding_done);
    @(posedge clk_i);
    while (pending_words.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d words (%0d steps), %0d printed values, %0d faulted words",
             n_items, n_steps, n_prints, n_faults);
    if (n_fail == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
